### src/ersj_pkg.sv
// Shared types, constants and arithmetic helpers for the repeater squelch and jam block.
package ersj_pkg;

	localparam int SAMPLE_WIDTH = 16;
	localparam int POLE_WIDTH   = 16;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 16;

	typedef logic [SAMPLE_WIDTH-1:0] sample_t;
	typedef logic [CFG_IDX_W-1:0]    cfg_idx_t;

	typedef enum logic [2:0] {
		MODE_IDLE = 3'd0,
		MODE_L2R  = 3'd1,
		MODE_R2L  = 3'd2,
		MODE_COLL = 3'd3,
		MODE_JAM  = 3'd4
	} mode_t;

	localparam cfg_idx_t REG_HALF_BIT = 3'd0;
	localparam cfg_idx_t REG_SQUELCH  = 3'd1;
	localparam cfg_idx_t REG_PEAK     = 3'd2;
	localparam cfg_idx_t REG_POLE     = 3'd3;
	localparam cfg_idx_t REG_JAM_LIM  = 3'd4;

	localparam logic [7:0]            RST_HALF_BIT = 8'd8;
	localparam logic [14:0]           RST_SQUELCH  = 15'd1434;
	localparam logic [14:0]           RST_PEAK     = 15'd5734;
	localparam logic [POLE_WIDTH-1:0] RST_POLE     = 16'd6554;
	localparam logic [7:0]            RST_JAM_LIM  = 8'd10;

	// Magnitude of a two's complement sample; the most negative value maps to 2^(W-1).
	function automatic sample_t magnitude(input sample_t x);
		return x[SAMPLE_WIDTH-1] ? (~x + 1'b1) : x;
	endfunction

	// One-pole follower written as env + floor(p * (mag - env) / 2^16),
	// which equals the two-product form exactly.
	function automatic sample_t follow(input sample_t env, input sample_t mag,
			input logic [POLE_WIDTH-1:0] p);
		logic signed [SAMPLE_WIDTH:0]               diff;
		logic signed [SAMPLE_WIDTH+POLE_WIDTH+1:0] prod;
		diff = $signed({1'b0, mag}) - $signed({1'b0, env});
		prod = $signed({1'b0, p}) * diff;
		return env + sample_t'(prod[SAMPLE_WIDTH+POLE_WIDTH-1:POLE_WIDTH]);
	endfunction

endpackage

### src/ethernet_repeater_squelch_jam.sv
// Two-port repeater with envelope squelch, collision detection and jam generation.
//
// Input channel (in_valid / in_stall) carries one sample time per word: left and
// right data samples and left and right collision-detect samples. Output channel
// (out_valid / out_stall) returns one word per input word: the drive for each port
// and the mode after that sample. The configuration channel (cfg_valid / cfg_ready)
// writes one register per word by index; cfg_ready is always high, and writes are
// expected only while no word is in flight.
// A word accepted into the input register passes the envelope multipliers and the
// state machine into the output register, where it is offered on the output.
// Throughput is one word per cycle while the output is not stalled; the critical path
// is one 17x17 multiply per envelope followed by the threshold compares and the next-state logic.
// A stalled output word holds; the input register keeps taking a new word whenever
// the output register is empty or being emptied, so in_stall follows out_stall only
// when both stages are full.
// Reset clears both valid flags, the envelopes, the mode (idle), the jam counters
// and phase, and loads the register defaults.
module ethernet_repeater_squelch_jam (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [ersj_pkg::SAMPLE_WIDTH-1:0] left_data,
	input  logic signed [ersj_pkg::SAMPLE_WIDTH-1:0] left_collision,
	input  logic signed [ersj_pkg::SAMPLE_WIDTH-1:0] right_data,
	input  logic signed [ersj_pkg::SAMPLE_WIDTH-1:0] right_collision,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [ersj_pkg::SAMPLE_WIDTH-1:0] left_drive,
	output logic signed [ersj_pkg::SAMPLE_WIDTH-1:0] right_drive,
	output logic [2:0]                          mode,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ersj_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ersj_pkg::CFG_DATA_W-1:0]     cfg_data
);

	// Configuration registers.
	logic [7:0]                        half_bit_samples_q;
	logic [14:0]                       squelch_level_q;
	logic [14:0]                       peak_level_q;
	logic [ersj_pkg::POLE_WIDTH-1:0]   pole_coeff_q;
	logic [7:0]                        jam_cycle_limit_q;

	// Input stage.
	logic              valid_s1;
	ersj_pkg::sample_t left_data_s1, left_coll_s1, right_data_s1, right_coll_s1;

	// Output stage.
	logic              valid_s2;
	ersj_pkg::sample_t left_drive_s2, right_drive_s2;
	ersj_pkg::mode_t   mode_s2;

	// Block state.
	ersj_pkg::mode_t   mode_q, mode_n;
	ersj_pkg::sample_t left_data_env_q, right_data_env_q, left_coll_env_q, right_coll_env_q;
	ersj_pkg::sample_t left_data_env_n, right_data_env_n, left_coll_env_n, right_coll_env_n;
	logic [7:0]        jam_cycles_q, jam_cycles_n;
	logic [7:0]        half_bit_count_q, half_bit_count_n;
	logic              jam_high_q, jam_high_n;

	logic              advance, fire;
	ersj_pkg::sample_t squelch_ext, peak_pos, peak_neg;
	logic              left_active, right_active, coll_active, coll_clear;
	logic              flip, phase_w, jam_inc;
	logic [7:0]        count_w, jam_cycles_w;
	ersj_pkg::sample_t jam_level, left_rep, right_rep;
	ersj_pkg::sample_t left_drive_n, right_drive_n;

	assign advance   = !valid_s2 || !out_stall;
	assign fire      = valid_s1 && advance;
	assign in_stall  = valid_s1 && !advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_bit_samples_q <= ersj_pkg::RST_HALF_BIT;
			squelch_level_q    <= ersj_pkg::RST_SQUELCH;
			peak_level_q       <= ersj_pkg::RST_PEAK;
			pole_coeff_q       <= ersj_pkg::RST_POLE;
			jam_cycle_limit_q  <= ersj_pkg::RST_JAM_LIM;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ersj_pkg::REG_HALF_BIT: half_bit_samples_q <= cfg_data[7:0];
				ersj_pkg::REG_SQUELCH:  squelch_level_q    <= cfg_data[14:0];
				ersj_pkg::REG_PEAK:     peak_level_q       <= cfg_data[14:0];
				ersj_pkg::REG_POLE:     pole_coeff_q       <= cfg_data[ersj_pkg::POLE_WIDTH-1:0];
				ersj_pkg::REG_JAM_LIM:  jam_cycle_limit_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			left_data_s1  <= left_data;
			left_coll_s1  <= left_collision;
			right_data_s1 <= right_data;
			right_coll_s1 <= right_collision;
		end
	end

	// Envelopes follow the magnitude of each input; compares use the new values.
	always_comb begin
		left_data_env_n  = ersj_pkg::follow(left_data_env_q,
			ersj_pkg::magnitude(left_data_s1), pole_coeff_q);
		right_data_env_n = ersj_pkg::follow(right_data_env_q,
			ersj_pkg::magnitude(right_data_s1), pole_coeff_q);
		left_coll_env_n  = ersj_pkg::follow(left_coll_env_q,
			ersj_pkg::magnitude(left_coll_s1), pole_coeff_q);
		right_coll_env_n = ersj_pkg::follow(right_coll_env_q,
			ersj_pkg::magnitude(right_coll_s1), pole_coeff_q);
	end

	assign squelch_ext  = {1'b0, squelch_level_q};
	assign peak_pos     = {1'b0, peak_level_q};
	assign peak_neg     = ~peak_pos + 1'b1;
	assign left_active  = left_data_env_n > squelch_ext;
	assign right_active = right_data_env_n > squelch_ext;
	assign coll_active  = (left_coll_env_n > squelch_ext) || (right_coll_env_n > squelch_ext);
	assign coll_clear   = (left_coll_env_n < squelch_ext) && (right_coll_env_n < squelch_ext);

	// Jam wave step: flip the phase once the half period is used up.
	assign flip         = half_bit_count_q >= half_bit_samples_q;
	assign phase_w      = flip ? !jam_high_q : jam_high_q;
	assign count_w      = (flip ? 8'd0 : half_bit_count_q) + 8'd1;
	assign jam_inc      = flip && !jam_high_q && (jam_cycles_q != 8'hFF);
	assign jam_cycles_w = jam_cycles_q + {7'd0, jam_inc};
	assign jam_level    = phase_w ? peak_pos : peak_neg;

	// Sign of the active side repeated as plus or minus peak.
	assign left_rep  = (left_data_s1 != '0 && !left_data_s1[ersj_pkg::SAMPLE_WIDTH-1])
		? peak_pos : peak_neg;
	assign right_rep = (right_data_s1 != '0 && !right_data_s1[ersj_pkg::SAMPLE_WIDTH-1])
		? peak_pos : peak_neg;

	always_comb begin
		mode_n           = mode_q;
		jam_cycles_n     = jam_cycles_q;
		half_bit_count_n = half_bit_count_q;
		jam_high_n       = jam_high_q;
		unique case (mode_q)
			ersj_pkg::MODE_L2R: begin
				if (!left_active)
					mode_n = ersj_pkg::MODE_IDLE;
				if (coll_active)
					mode_n = ersj_pkg::MODE_COLL;
			end
			ersj_pkg::MODE_R2L: begin
				if (!right_active)
					mode_n = ersj_pkg::MODE_IDLE;
				if (coll_active)
					mode_n = ersj_pkg::MODE_COLL;
			end
			ersj_pkg::MODE_COLL: begin
				half_bit_count_n = count_w;
				jam_high_n       = phase_w;
				if (coll_clear) begin
					jam_cycles_n = 8'd0;
					mode_n       = ersj_pkg::MODE_JAM;
				end
			end
			ersj_pkg::MODE_JAM: begin
				half_bit_count_n = count_w;
				jam_high_n       = phase_w;
				jam_cycles_n     = jam_cycles_w;
				if (coll_active) begin
					jam_cycles_n = 8'd0;
					mode_n       = ersj_pkg::MODE_COLL;
				end else if (jam_cycles_w > jam_cycle_limit_q) begin
					jam_cycles_n = 8'd0;
					mode_n       = ersj_pkg::MODE_IDLE;
				end
			end
			default: begin
				if (left_active)
					mode_n = ersj_pkg::MODE_L2R;
				else if (right_active)
					mode_n = ersj_pkg::MODE_R2L;
				else if (coll_active)
					mode_n = ersj_pkg::MODE_COLL;
				else
					mode_n = ersj_pkg::MODE_IDLE;
			end
		endcase
	end

	always_comb begin
		left_drive_n  = '0;
		right_drive_n = '0;
		unique case (mode_q)
			ersj_pkg::MODE_L2R: begin
				if (left_active)
					right_drive_n = left_rep;
			end
			ersj_pkg::MODE_R2L: begin
				if (right_active)
					left_drive_n = right_rep;
			end
			ersj_pkg::MODE_COLL, ersj_pkg::MODE_JAM: begin
				left_drive_n  = jam_level;
				right_drive_n = jam_level;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q           <= ersj_pkg::MODE_IDLE;
			left_data_env_q  <= '0;
			right_data_env_q <= '0;
			left_coll_env_q  <= '0;
			right_coll_env_q <= '0;
			jam_cycles_q     <= '0;
			half_bit_count_q <= '0;
			jam_high_q       <= 1'b0;
		end else if (fire) begin
			mode_q           <= mode_n;
			left_data_env_q  <= left_data_env_n;
			right_data_env_q <= right_data_env_n;
			left_coll_env_q  <= left_coll_env_n;
			right_coll_env_q <= right_coll_env_n;
			jam_cycles_q     <= jam_cycles_n;
			half_bit_count_q <= half_bit_count_n;
			jam_high_q       <= jam_high_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			left_drive_s2  <= left_drive_n;
			right_drive_s2 <= right_drive_n;
			mode_s2        <= mode_n;
		end
	end

	assign out_valid   = valid_s2;
	assign left_drive  = $signed(left_drive_s2);
	assign right_drive = $signed(right_drive_s2);
	assign mode        = mode_s2;

endmodule
